// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file lpfp_checker.sv
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication, checked on the rising clock edge outside reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ----- hdl/lpfp_pkg.sv -----
// types and constants of the length-prefixed frame parser
// no dependencies
`default_nettype none

package lpfp_pkg;

  localparam int unsigned LEN_BYTES = 8;              // bytes in one length field
  localparam int unsigned LEN_W     = 64;             // width of an assembled length
  localparam int unsigned CNT_W     = 3;              // length byte counter
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned KIND_W    = 2;
  localparam logic [CNT_W-1:0] LEN_LAST = CNT_W'(LEN_BYTES - 1);

  typedef enum logic [1:0] {
    PH_NAME_LEN = 2'd0,
    PH_NAME     = 2'd1,
    PH_PAY_LEN  = 2'd2,
    PH_PAYLOAD  = 2'd3
  } phase_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_LENGTH  = 2'd0,
    KIND_NAME    = 2'd1,
    KIND_PAYLOAD = 2'd2
  } kind_e;

endpackage

`default_nettype wire

// ----- hdl/lpfp_if.sv -----
// byte and result channel interfaces of the frame parser
// depends on lpfp_pkg
`default_nettype none

interface lpfp_byte_if import lpfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface lpfp_res_if import lpfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [DATA_W-1:0] data_out;
  logic              length_done;
  logic [LEN_W-1:0]  length_value;
  logic              name_last;
  logic              is_file;
  logic              frame_end;

  modport source (output valid, output kind, output data_out, output length_done,
                  output length_value, output name_last, output is_file,
                  output frame_end, input ready);
  modport sink   (input valid, input kind, input data_out, input length_done,
                  input length_value, input name_last, input is_file,
                  input frame_end, output ready);
endinterface

`default_nettype wire

// ----- hdl/length_prefixed_frame_parser_core.sv -----
// byte-serial deframer for length-prefixed frames: one tagged result per byte
// depends on lpfp_pkg and the interfaces in lpfp_if.sv
//
//   channel    dir  modport  beat
//   byte_i     in   sink     one received byte (byte_in)
//   result_o   out  source   tag, byte, completed length, name/frame markers
//
// one byte per cycle while result_o.ready stays high; a result appears in the cycle after its byte is taken
// the parse state and the result register update in the same cycle, so the only
// work between registers is one 64-bit decrement/compare and one byte-lane merge
// rst_ni clears the parse state and empties the result register at once
// byte_i.ready drops only while a result is held and result_o.ready is low
`default_nettype none

module length_prefixed_frame_parser_core import lpfp_pkg::*; (
  input  wire           clk_i,
  input  wire           rst_ni,
  lpfp_byte_if.sink     byte_i,
  lpfp_res_if.source    result_o
);

  // parse state
  phase_e             phase_q, phase_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [LEN_W-1:0]   accum_q, accum_d;
  logic [LEN_W-1:0]   rem_q, rem_d;
  logic               has_name_q, has_name_d;

  // result register
  logic               res_valid_q;
  kind_e              kind_q, kind_d;
  logic [DATA_W-1:0]  data_q;
  logic               ldone_q, ldone_d;
  logic [LEN_W-1:0]   lval_q, lval_d;
  logic               nlast_q, nlast_d;
  logic               isf_q, isf_d;
  logic               fend_q, fend_d;

  logic               in_fire;
  logic [LEN_W-1:0]   assembled;
  logic               len_last;
  logic               rem_last;
  logic               has_name_upd;
  logic               clear_name;

  // new byte goes in whenever the result slot is free or being emptied
  assign byte_i.ready = !res_valid_q || result_o.ready;
  assign in_fire      = byte_i.valid && byte_i.ready;

  // merge the incoming byte into its little-endian lane of the length
  always_comb begin
    for (int i = 0; i < LEN_W / DATA_W; i++) begin
      assembled[DATA_W*i +: DATA_W] = accum_q[DATA_W*i +: DATA_W] |
          ((cnt_q == CNT_W'(i)) ? byte_i.byte_in : '0);
    end
  end

  assign len_last = (cnt_q >= LEN_LAST);
  assign rem_last = (rem_q == LEN_W'(1));

  // next state and result fields
  always_comb begin
    phase_d      = phase_q;
    cnt_d        = cnt_q;
    accum_d      = accum_q;
    rem_d        = rem_q;
    has_name_upd = has_name_q;
    clear_name   = 1'b0;
    kind_d       = KIND_LENGTH;
    ldone_d      = 1'b0;
    lval_d       = '0;
    nlast_d      = 1'b0;
    fend_d       = 1'b0;

    unique case (phase_q)
      PH_NAME_LEN: begin
        kind_d = KIND_LENGTH;
        if (len_last) begin
          ldone_d = 1'b1;
          lval_d  = assembled;
          accum_d = '0;
          cnt_d   = '0;
          if (assembled == '0) begin
            // empty name: text message, go straight to payload length
            has_name_upd = 1'b0;
            phase_d      = PH_PAY_LEN;
          end else begin
            has_name_upd = 1'b1;
            rem_d        = assembled;
            phase_d      = PH_NAME;
          end
        end else begin
          accum_d = assembled;
          cnt_d   = cnt_q + CNT_W'(1);
        end
      end
      PH_NAME: begin
        kind_d = KIND_NAME;
        rem_d  = rem_q - LEN_W'(1);
        if (rem_last) begin
          nlast_d = 1'b1;
          phase_d = PH_PAY_LEN;
        end
      end
      PH_PAY_LEN: begin
        kind_d = KIND_LENGTH;
        if (len_last) begin
          ldone_d = 1'b1;
          lval_d  = assembled;
          accum_d = '0;
          cnt_d   = '0;
          if (assembled == '0) begin
            // empty payload ends the frame on its last length byte
            fend_d     = 1'b1;
            clear_name = 1'b1;
            phase_d    = PH_NAME_LEN;
          end else begin
            rem_d   = assembled;
            phase_d = PH_PAYLOAD;
          end
        end else begin
          accum_d = assembled;
          cnt_d   = cnt_q + CNT_W'(1);
        end
      end
      PH_PAYLOAD: begin
        kind_d = KIND_PAYLOAD;
        rem_d  = rem_q - LEN_W'(1);
        if (rem_last) begin
          fend_d     = 1'b1;
          clear_name = 1'b1;
          phase_d    = PH_NAME_LEN;
        end
      end
      default: begin
        phase_d = PH_NAME_LEN;
      end
    endcase

    // is_file shows the frame just finished, then the flag clears
    isf_d      = has_name_upd;
    has_name_d = clear_name ? 1'b0 : has_name_upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_NAME_LEN;
      cnt_q      <= '0;
      accum_q    <= '0;
      rem_q      <= '0;
      has_name_q <= 1'b0;
    end else if (in_fire) begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      accum_q    <= accum_d;
      rem_q      <= rem_d;
      has_name_q <= has_name_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (in_fire) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // result payload, loaded with each accepted byte
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q  <= kind_d;
      data_q  <= byte_i.byte_in;
      ldone_q <= ldone_d;
      lval_q  <= lval_d;
      nlast_q <= nlast_d;
      isf_q   <= isf_d;
      fend_q  <= fend_d;
    end
  end

  assign result_o.valid        = res_valid_q;
  assign result_o.kind         = kind_q;
  assign result_o.data_out     = data_q;
  assign result_o.length_done  = ldone_q;
  assign result_o.length_value = lval_q;
  assign result_o.name_last    = nlast_q;
  assign result_o.is_file      = isf_q;
  assign result_o.frame_end    = fend_q;

endmodule

`default_nettype wire

// ----- hdl/lpfp_checker.sv -----
// port-level checks for the frame parser, bound to the top level
// depends on assert_macros.svh and length_prefixed_frame_parser_core
`default_nettype none

`include "assert_macros.svh"

module lpfp_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_ready_i,
  input wire [7:0] in_byte_i,
  input wire       out_valid_i,
  input wire       out_ready_i,
  input wire [7:0] out_data_i
);

  // every accepted byte shows up as a result in the next cycle
  `ASSERT_NXT(a_byte_to_result, clk_i, rst_ni, in_valid_i && in_ready_i, out_valid_i && out_data_i == $past(in_byte_i))

  // a held result blocks new bytes
  `ASSERT_IMP(a_backpressure, clk_i, rst_ni, out_valid_i && !out_ready_i, !in_ready_i)

  // stalled result stays put
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i))

endmodule

bind length_prefixed_frame_parser_core lpfp_checker u_lpfp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (byte_i.valid),
  .in_ready_i  (byte_i.ready),
  .in_byte_i   (byte_i.byte_in),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_data_i  (result_o.data_out)
);

`default_nettype wire

// ----- test/tb_length_prefixed_frame_parser_core.sv -----
// self-checking bench for length_prefixed_frame_parser_core: frames go in byte by byte and
// every tagged result is compared with a cycle-free parser kept here
// depends on lpfp_pkg, lpfp_if.sv and the core
`default_nettype none

module tb_length_prefixed_frame_parser_core;
  import lpfp_pkg::*;

  localparam int unsigned ITEM_TARGET = 1350;  // rough size of the byte stream
  localparam int unsigned CALM_FROM   = 1100;  // no idling from here to the end
  localparam int unsigned STALL_LIMIT = 1000;  // cycles without any beat
  localparam int unsigned TAIL_CYCLES = 8;     // settle time after the last result
  localparam int unsigned PRINT_MAX   = 40;

  // one queued input byte plus how it is to be sent
  typedef struct {
    logic [DATA_W-1:0] b;
    bit                drain;  // hold off until every pending result is back
    bit                calm;   // part of the idle-free tail
  } stim_t;

  typedef struct packed {
    kind_e             kind;
    logic [DATA_W-1:0] data;
    logic              len_done;
    logic [LEN_W-1:0]  len_val;
    logic              name_last;
    logic              is_file;
    logic              frame_end;
  } parse_result_t;

  logic clk_i;
  logic rst_ni;

  lpfp_byte_if byte_ch ();
  lpfp_res_if  res_ch ();

  length_prefixed_frame_parser_core uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_ch),
    .result_o (res_ch)
  );

  stim_t         byte_q[$];      // bytes still to be sent
  parse_result_t expected_q[$];  // results owed by the core, oldest first
  int unsigned   errors;
  int unsigned   results_seen;
  int unsigned   gap_left;
  int unsigned   stall_left;
  int unsigned   quiet_cycles;
  bit            quiet;          // set once the idle-free tail starts

  // parser state, mirrors what the core keeps
  phase_e           ph;
  logic [CNT_W-1:0] len_cnt;
  logic [LEN_W-1:0] len_acc;
  logic [LEN_W-1:0] remain;
  logic             has_name;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // advance the parser by one byte and return the result that byte must produce
  function automatic parse_result_t parse_byte(input logic [DATA_W-1:0] b);
    parse_result_t    r;
    logic             done;
    logic [LEN_W-1:0] v;
    logic             clr;
    r       = '0;
    r.kind  = KIND_LENGTH;
    r.data  = b;
    done    = 1'b0;
    v       = '0;
    clr     = 1'b0;
    // both length phases assemble little-endian into the same accumulator
    if (ph == PH_NAME_LEN || ph == PH_PAY_LEN) begin
      len_acc = len_acc | (LEN_W'(b) << (8 * len_cnt));
      if (len_cnt == LEN_LAST) begin
        done    = 1'b1;
        v       = len_acc;
        len_acc = '0;
        len_cnt = '0;
      end else begin
        len_cnt = len_cnt + 1'b1;
      end
    end
    case (ph)
      PH_NAME_LEN: begin
        if (done) begin
          r.len_done = 1'b1;
          r.len_val  = v;
          // an empty name means a text message: skip straight to the payload length
          if (v == '0) begin
            has_name = 1'b0;
            ph       = PH_PAY_LEN;
          end else begin
            has_name = 1'b1;
            remain   = v;
            ph       = PH_NAME;
          end
        end
      end
      PH_NAME: begin
        r.kind = KIND_NAME;
        remain = remain - 1'b1;
        if (remain == '0) begin
          r.name_last = 1'b1;
          ph          = PH_PAY_LEN;
        end
      end
      PH_PAY_LEN: begin
        if (done) begin
          r.len_done = 1'b1;
          r.len_val  = v;
          // zero payload: the last length byte closes the frame
          if (v == '0) begin
            r.frame_end = 1'b1;
            clr         = 1'b1;
            ph          = PH_NAME_LEN;
          end else begin
            remain = v;
            ph     = PH_PAYLOAD;
          end
        end
      end
      default: begin
        r.kind = KIND_PAYLOAD;
        remain = remain - 1'b1;
        if (remain == '0) begin
          r.frame_end = 1'b1;
          clr         = 1'b1;
          ph          = PH_NAME_LEN;
        end
      end
    endcase
    // is_file still shows the frame on its closing byte, cleared afterwards
    r.is_file = has_name;
    if (clr) has_name = 1'b0;
    return r;
  endfunction

  task automatic report(input string what, input logic [LEN_W-1:0] got,
                        input logic [LEN_W-1:0] want);
    if (errors < PRINT_MAX)
      $display("result %0d: %s got 0x%0h, expected 0x%0h", results_seen, what, got, want);
    errors++;
  endtask

  task automatic push_byte(input logic [DATA_W-1:0] b, input bit drain, input bit calm);
    stim_t s;
    s.b     = b;
    s.drain = drain;
    s.calm  = calm;
    byte_q.push_back(s);
  endtask

  // whole frame: name length, name, payload length, payload; contents random
  task automatic push_frame(input logic [LEN_W-1:0] name_len, input int unsigned name_cnt,
                            input logic [LEN_W-1:0] pay_len, input int unsigned pay_cnt,
                            input bit drain, input bit calm);
    for (int i = 0; i < LEN_BYTES; i++)
      push_byte(name_len[8*i +: 8], drain && i == 0, calm);
    for (int unsigned i = 0; i < name_cnt; i++)
      push_byte(8'($urandom), 1'b0, calm);
    for (int i = 0; i < LEN_BYTES; i++)
      push_byte(pay_len[8*i +: 8], 1'b0, calm);
    for (int unsigned i = 0; i < pay_cnt; i++)
      push_byte(8'($urandom), 1'b0, calm);
  endtask

  // byte driver: random idle bursts, optional drain hold-off, then the idle-free tail
  always @(posedge clk_i or negedge rst_ni) begin
    parse_result_t r;
    bit            fire;
    if (!rst_ni) begin
      byte_ch.valid   <= 1'b0;
      byte_ch.byte_in <= '0;
      gap_left        <= 0;
      quiet           <= 1'b0;
      ph              = PH_NAME_LEN;
      len_cnt         = '0;
      len_acc         = '0;
      remain          = '0;
      has_name        = 1'b0;
    end else begin
      fire = byte_ch.valid && byte_ch.ready;
      if (fire) begin
        r = parse_byte(byte_ch.byte_in);
        expected_q.push_back(r);
      end
      if (byte_ch.valid && !fire) begin
        // beat still on offer, hold it
      end else if (gap_left != 0) begin
        byte_ch.valid <= 1'b0;
        gap_left      <= gap_left - 1;
      end else if (byte_q.size() == 0) begin
        byte_ch.valid <= 1'b0;
      end else if (byte_q[0].drain && expected_q.size() != 0) begin
        // let the core run dry before this byte goes in
        byte_ch.valid <= 1'b0;
      end else if (!byte_q[0].calm && $urandom_range(0, 11) == 0) begin
        byte_ch.valid <= 1'b0;
        gap_left      <= $urandom_range(0, 14);
      end else begin
        byte_ch.valid   <= 1'b1;
        byte_ch.byte_in <= byte_q[0].b;
        if (byte_q[0].calm) quiet <= 1'b1;
        byte_q.delete(0);
      end
    end
  end

  // result monitor and backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    parse_result_t want;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected beat, kind", LEN_W'(res_ch.kind), '0);
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          if (res_ch.kind !== want.kind)
            report("kind", LEN_W'(res_ch.kind), LEN_W'(want.kind));
          if (res_ch.data_out !== want.data)
            report("data_out", LEN_W'(res_ch.data_out), LEN_W'(want.data));
          if (res_ch.length_done !== want.len_done)
            report("length_done", LEN_W'(res_ch.length_done), LEN_W'(want.len_done));
          if (res_ch.length_value !== want.len_val)
            report("length_value", res_ch.length_value, want.len_val);
          if (res_ch.name_last !== want.name_last)
            report("name_last", LEN_W'(res_ch.name_last), LEN_W'(want.name_last));
          if (res_ch.is_file !== want.is_file)
            report("is_file", LEN_W'(res_ch.is_file), LEN_W'(want.is_file));
          if (res_ch.frame_end !== want.frame_end)
            report("frame_end", LEN_W'(res_ch.frame_end), LEN_W'(want.frame_end));
        end
        results_seen <= results_seen + 1;
      end
      if (stall_left != 0) begin
        res_ch.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        res_ch.ready <= 1'b0;
        stall_left   <= $urandom_range(0, 14);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog: too long without a beat on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [LEN_W-1:0] nlen;
    logic [LEN_W-1:0] plen;
    bit               calm;
    errors          = 0;
    results_seen    = 0;
    quiet_cycles    = 0;
    rst_ni          = 1'b0;
    byte_ch.valid   = 1'b0;
    byte_ch.byte_in = '0;
    res_ch.ready    = 1'b0;

    // directed: text message with empty payload, then one-byte name and two-byte payload
    push_frame('0, 0, '0, 0, 1'b0, 1'b0);
    push_frame(64'd1, 1, 64'd2, 2, 1'b0, 1'b0);

    // random well-formed frames; mostly short, a few with long names or payloads
    while (byte_q.size() < ITEM_TARGET) begin
      calm = byte_q.size() >= CALM_FROM;
      if ($urandom_range(0, 2) == 0)       nlen = '0;
      else if ($urandom_range(0, 19) == 0) nlen = LEN_W'($urandom_range(9, 40));
      else                                 nlen = LEN_W'($urandom_range(1, 8));
      if ($urandom_range(0, 3) == 0)       plen = '0;
      else if ($urandom_range(0, 24) == 0) plen = LEN_W'($urandom_range(200, 300));
      else                                 plen = LEN_W'($urandom_range(1, 12));
      // the first random frame waits for the directed results to drain
      push_frame(nlen, int'(nlen), plen, int'(plen),
                 byte_q.size() == 35 || (!calm && $urandom_range(0, 49) == 0), calm);
    end

    // broken tail: all-ones name length, so the name never ends
    for (int i = 0; i < LEN_BYTES; i++) push_byte(8'hFF, 1'b0, 1'b1);
    for (int i = 0; i < 24; i++) push_byte(8'($urandom), 1'b0, 1'b1);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_q.size() != 0 || byte_ch.valid || expected_q.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_q.size() != 0)
      report("results left over, count", LEN_W'(expected_q.size()), '0);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- length_prefixed_frame_parser_core.f -----
+incdir+hdl
hdl/lpfp_pkg.sv
hdl/lpfp_if.sv
hdl/length_prefixed_frame_parser_core.sv
hdl/lpfp_checker.sv
test/tb_length_prefixed_frame_parser_core.sv
